// File: src/ols_pkg.sv
// Shared types and codes for the ordered list store.
`default_nettype none

package ols_pkg;

  localparam int IDX_W = 11;
  localparam int VAL_W = 32;
  localparam int OUT_CNT_W = 7;

  typedef enum logic [1:0] {
    OP_APPEND = 2'd0,
    OP_DELETE = 2'd1,
    OP_SEARCH = 2'd2,
    OP_NONE   = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    ST_OK     = 3'd0,
    ST_EMPTY  = 3'd1,
    ST_BELOW  = 3'd2,
    ST_BEYOND = 3'd3,
    ST_FULL   = 3'd4
  } status_t;

  typedef struct packed {
    logic                    append;
    logic                    remove;
    logic                    search;
    logic [IDX_W-1:0]        tail;
    logic [IDX_W-1:0]        gap;
    logic [IDX_W-1:0]        limit;
    logic signed [VAL_W-1:0] key;
  } cmd_t;

endpackage

`default_nettype wire

// File: src/ols_cell.sv
// One list slot: holds an entry, shifts down on delete, passes the search hit along.
`default_nettype none

module ols_cell #(
  parameter int IDX = 0
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire ols_pkg::cmd_t                    cmd,
  input  wire logic signed [ols_pkg::VAL_W-1:0] right_data,
  input  wire logic                             hit_in,
  output logic signed [ols_pkg::VAL_W-1:0]      data_out,
  output logic                                  hit_out
);

  localparam logic [ols_pkg::IDX_W-1:0] MY_IDX = ols_pkg::IDX_W'(IDX);

  logic signed [ols_pkg::VAL_W-1:0] data_r, data_nxt;
  logic                             hit_r, hit_nxt;
  logic                             valid;
  logic                             match;

  always_comb begin
    valid = (MY_IDX < cmd.limit);
    match = valid && (data_r == cmd.key);
    data_nxt = data_r;
    if (cmd.append && (MY_IDX == cmd.tail)) begin
      data_nxt = cmd.key;
    end else if (cmd.remove && (MY_IDX >= cmd.gap)) begin
      data_nxt = right_data;
    end
    hit_nxt = cmd.search && (hit_in || match);
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hit_r <= 1'b0;
    end else begin
      hit_r <= hit_nxt;
    end
  end

  assign data_out = data_r;
  assign hit_out  = hit_r;

endmodule

`default_nettype wire

// File: src/ordered_list_store.sv
// Top level of the ordered list store: control, length counter and the row of slots.
`default_nettype none

// Bounded list of signed 32-bit values in insertion order, held in a row of DEPTH
// slots. Append, delete and the unused code need no scan: the result strobe
// out_valid rises in the cycle after start is taken and busy stays low, so one such
// item can be taken every cycle. Search passes a hit flag down the row one slot per
// cycle while busy is high, and the result strobe comes in the same cycle that busy
// falls, when the next item may already be taken. Results are shown for one cycle
// only and cannot be held off, so the receiver must take each one as it comes.
module ordered_list_store #(
  parameter int DEPTH = 64
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             start,
  output logic                                  busy,
  input  wire logic [1:0]                       in_operation,
  input  wire logic signed [ols_pkg::VAL_W-1:0] in_value,
  input  wire logic [7:0]                       in_position,
  output logic                                  out_valid,
  output logic                                  out_found,
  output logic [2:0]                            out_status,
  output logic [ols_pkg::OUT_CNT_W-1:0]         out_count
);

  localparam int CNT_W  = $clog2(DEPTH + 1);
  localparam int SCAN_W = $clog2(DEPTH + 1);
  localparam logic [ols_pkg::IDX_W-1:0] FULL_CNT = ols_pkg::IDX_W'(DEPTH);
  localparam logic [SCAN_W-1:0] SCAN_END = SCAN_W'(DEPTH);

  typedef enum logic [1:0] {
    S_IDLE   = 2'b01,
    S_SEARCH = 2'b10
  } state_t;

  state_t                           state_r, state_nxt;
  logic [CNT_W-1:0]                 count_r, count_nxt;
  logic [SCAN_W-1:0]                scan_r, scan_nxt;
  logic signed [ols_pkg::VAL_W-1:0] key_r, key_nxt;
  logic                             valid_r, valid_nxt;
  logic                             found_r, found_nxt;
  ols_pkg::status_t                 status_r, status_nxt;
  logic [ols_pkg::OUT_CNT_W-1:0]    ocount_r, ocount_nxt;

  ols_pkg::cmd_t                    cmd;
  logic [ols_pkg::IDX_W-1:0]        cnt_ext;
  logic [ols_pkg::IDX_W-1:0]        pos_ext;
  logic                             accept;
  ols_pkg::op_t                     op;

  logic signed [ols_pkg::VAL_W-1:0] data_w [DEPTH];
  logic                             hit_w  [DEPTH];

  always_comb begin
    cnt_ext = ols_pkg::IDX_W'(count_r);
    pos_ext = ols_pkg::IDX_W'(in_position);
    accept  = start && (state_r == S_IDLE);
    op      = ols_pkg::op_t'(in_operation);

    state_nxt  = state_r;
    count_nxt  = count_r;
    scan_nxt   = scan_r;
    key_nxt    = key_r;
    valid_nxt  = 1'b0;
    found_nxt  = found_r;
    status_nxt = status_r;
    ocount_nxt = ocount_r;

    cmd.append = 1'b0;
    cmd.remove = 1'b0;
    cmd.search = (state_r == S_SEARCH);
    cmd.tail   = cnt_ext;
    cmd.gap    = pos_ext - ols_pkg::IDX_W'(1);
    cmd.limit  = cnt_ext;
    cmd.key    = (state_r == S_SEARCH) ? key_r : in_value;

    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          found_nxt  = 1'b0;
          status_nxt = ols_pkg::ST_OK;
          unique case (op)
            ols_pkg::OP_APPEND: begin
              valid_nxt = 1'b1;
              if (cnt_ext >= FULL_CNT) begin
                status_nxt = ols_pkg::ST_FULL;
              end else begin
                cmd.append = 1'b1;
                count_nxt  = count_r + CNT_W'(1);
              end
            end
            ols_pkg::OP_DELETE: begin
              valid_nxt = 1'b1;
              if (count_r == '0) begin
                status_nxt = ols_pkg::ST_EMPTY;
              end else if (pos_ext == '0) begin
                status_nxt = ols_pkg::ST_BELOW;
              end else if (pos_ext > cnt_ext) begin
                status_nxt = ols_pkg::ST_BEYOND;
              end else begin
                cmd.remove = 1'b1;
                count_nxt  = count_r - CNT_W'(1);
              end
            end
            ols_pkg::OP_SEARCH: begin
              state_nxt = S_SEARCH;
              scan_nxt  = '0;
              key_nxt   = in_value;
            end
            default: begin
              valid_nxt = 1'b1;
            end
          endcase
          ocount_nxt = ols_pkg::OUT_CNT_W'(count_nxt);
        end
      end
      S_SEARCH: begin
        if (scan_r == SCAN_END) begin
          state_nxt  = S_IDLE;
          valid_nxt  = 1'b1;
          found_nxt  = hit_w[DEPTH-1];
          status_nxt = ols_pkg::ST_OK;
          ocount_nxt = ols_pkg::OUT_CNT_W'(count_r);
        end else begin
          scan_nxt = scan_r + SCAN_W'(1);
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      count_r <= '0;
      scan_r  <= '0;
      valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      scan_r  <= scan_nxt;
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    key_r    <= key_nxt;
    found_r  <= found_nxt;
    status_r <= status_nxt;
    ocount_r <= ocount_nxt;
  end

  genvar gi;
  generate
    for (gi = 0; gi < DEPTH; gi++) begin : g_cell
      logic signed [ols_pkg::VAL_W-1:0] right_w;
      logic                             hit_in_w;
      if (gi < DEPTH - 1) begin : g_mid
        assign right_w = data_w[gi+1];
      end else begin : g_last
        assign right_w = data_w[gi];
      end
      if (gi == 0) begin : g_first
        assign hit_in_w = 1'b0;
      end else begin : g_rest
        assign hit_in_w = hit_w[gi-1];
      end
      ols_cell #(
        .IDX(gi)
      ) u_cell (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .right_data (right_w),
        .hit_in     (hit_in_w),
        .data_out   (data_w[gi]),
        .hit_out    (hit_w[gi])
      );
    end
  endgenerate

  assign busy       = (state_r == S_SEARCH);
  assign out_valid  = valid_r;
  assign out_found  = found_r;
  assign out_status = status_r;
  assign out_count  = ocount_r;

endmodule

`default_nettype wire
